// ----- rtl/sorted_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Checked only while reset is released.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Sizes, request and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int TAG_W  = 32;
  localparam int PRIO_W = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOWER  = 2'd2;
  localparam logic [1:0] REQ_REPORT = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_URGENT   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic exec;
    logic place;
    logic load_out;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_place;
  } spq_sts_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by priority, then tag, over DEPTH slots.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_req_type, in_tag, in_priority_req
// out      output     out_valid, out_ready, out_tag, out_head_priority,
//                     out_entry_count, out_status
//
// An accepted beat goes to execute and, for an insert into a queue that is not
// full or an accepted priority change, then to a re-place state; the result
// is then loaded into the output register, and only after that does the
// controller return to idle and accept the next request, since it walks the
// single shift network of the slot array. A stalled output holds the
// next result in the datapath until the register frees. Reset (rst_n,
// synchronous, active low) empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [spq_pkg::TAG_W-1:0]         in_tag,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::TAG_W-1:0]         out_tag,
  output logic signed [spq_pkg::PRIO_W-1:0] out_head_priority,
  output logic [spq_pkg::CNT_W-1:0]         out_entry_count,
  output logic [2:0]                        out_status
);
  import spq_pkg::*;

  // The controller only sequences; every decision on queue contents is made
  // in the datapath, which tells the controller whether a re-place is due.
  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_tag            (in_tag),
    .in_priority_req   (in_priority_req),
    .out_tag           (out_tag),
    .out_head_priority (out_head_priority),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status)
  );

endmodule

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accept, execute, optional re-place, then load the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::spq_sts_t sts,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_PLACE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_place ? S_PLACE : S_DONE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with parallel compare, shift-out, shift-in and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spq_pkg::spq_cmd_t                cmd,
  output spq_pkg::spq_sts_t                sts,
  input  logic [1:0]                       in_req_type,
  input  logic [spq_pkg::TAG_W-1:0]        in_tag,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic [spq_pkg::TAG_W-1:0]        out_tag,
  output logic signed [spq_pkg::PRIO_W-1:0] out_head_priority,
  output logic [spq_pkg::CNT_W-1:0]        out_entry_count,
  output logic [2:0]                       out_status
);
  import spq_pkg::*;

  logic [TAG_W-1:0]         slot_tag_r  [DEPTH];
  logic signed [PRIO_W-1:0] slot_prio_r [DEPTH];
  logic [TAG_W-1:0]         slot_tag_nxt  [DEPTH];
  logic signed [PRIO_W-1:0] slot_prio_nxt [DEPTH];
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic [1:0]               req_type_r;
  logic [TAG_W-1:0]         req_tag_r;
  logic signed [PRIO_W-1:0] req_prio_r;
  logic                     removed_r, removed_nxt;
  logic [TAG_W-1:0]         rem_tag_r, rem_tag_nxt;
  logic [2:0]               status_r, status_nxt;

  logic [TAG_W-1:0]         out_tag_r;
  logic signed [PRIO_W-1:0] out_prio_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic [2:0]               out_status_r;

  logic [DEPTH-1:0]         live, match, seen, first, ahead, take_mask;
  logic signed [PRIO_W-1:0] found_prio;
  logic                     found, urgent, full, empty, do_take;

  // Per-slot compares against the latched request.
  always_comb begin
    found_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      live[i]  = CNT_W'(i) < count_r;
      match[i] = live[i] && (slot_tag_r[i] == req_tag_r);
      ahead[i] = live[i] && ((slot_prio_r[i] < req_prio_r) ||
                 ((slot_prio_r[i] == req_prio_r) && (slot_tag_r[i] < req_tag_r)));
    end
    seen[0]  = match[0];
    first[0] = match[0];
    for (int i = 1; i < DEPTH; i++) begin
      seen[i]  = seen[i-1] | match[i];
      first[i] = match[i] && !seen[i-1];
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) found_prio = found_prio | slot_prio_r[i];
    end
  end

  assign found  = seen[DEPTH-1];
  assign urgent = found_prio < req_prio_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign sts.need_place = ((req_type_r == REQ_INSERT) && !full) ||
                          ((req_type_r == REQ_LOWER) && found && !urgent);

  always_comb begin
    status_nxt  = status_r;
    removed_nxt = removed_r;
    rem_tag_nxt = rem_tag_r;
    count_nxt   = count_r;
    do_take     = 1'b0;
    take_mask   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_tag_nxt[i]  = slot_tag_r[i];
      slot_prio_nxt[i] = slot_prio_r[i];
    end

    if (cmd.load_req) begin
      removed_nxt = 1'b0;
    end

    if (cmd.exec) begin
      case (req_type_r)
        REQ_INSERT: begin
          status_nxt = full ? ST_FULL : ST_OK;
        end
        REQ_REMOVE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt  = ST_OK;
            removed_nxt = 1'b1;
            rem_tag_nxt = slot_tag_r[0];
            do_take     = 1'b1;
            take_mask   = '1;
          end
        end
        REQ_LOWER: begin
          if (!found) begin
            status_nxt = ST_NOTFOUND;
          end else if (urgent) begin
            status_nxt = ST_URGENT;
          end else begin
            status_nxt = ST_OK;
            do_take    = 1'b1;
            take_mask  = seen;
          end
        end
        REQ_REPORT: begin
          status_nxt = empty ? ST_EMPTY : ST_OK;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end

    // Take an entry out: every slot from it onward pulls from its neighbor.
    if (do_take) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (take_mask[i]) begin
          slot_tag_nxt[i]  = slot_tag_r[i+1];
          slot_prio_nxt[i] = slot_prio_r[i+1];
        end
      end
      count_nxt = count_r - CNT_W'(1);
    end

    // Place the request entry in front of the first slot that does not precede it.
    if (cmd.place) begin
      if (!ahead[0]) begin
        slot_tag_nxt[0]  = req_tag_r;
        slot_prio_nxt[0] = req_prio_r;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!ahead[i]) begin
          if (ahead[i-1]) begin
            slot_tag_nxt[i]  = req_tag_r;
            slot_prio_nxt[i] = req_prio_r;
          end else begin
            slot_tag_nxt[i]  = slot_tag_r[i-1];
            slot_prio_nxt[i] = slot_prio_r[i-1];
          end
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_tag_r[i]  <= slot_tag_nxt[i];
      slot_prio_r[i] <= slot_prio_nxt[i];
    end
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      req_tag_r  <= in_tag;
      req_prio_r <= in_priority_req;
    end
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    rem_tag_r <= rem_tag_nxt;
    if (cmd.load_out) begin
      out_tag_r    <= removed_r ? rem_tag_r : (empty ? '0 : slot_tag_r[0]);
      out_prio_r   <= empty ? '0 : slot_prio_r[0];
      out_cnt_r    <= count_r;
      out_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_tag           = out_tag_r;
  assign out_head_priority = out_prio_r;
  assign out_entry_count   = out_cnt_r;
  assign out_status        = out_status_r;

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [spq_pkg::TAG_W-1:0]         out_tag,
  input logic signed [spq_pkg::PRIO_W-1:0] out_head_priority,
  input logic [spq_pkg::CNT_W-1:0]         out_entry_count,
  input logic [2:0]                        out_status
);
  import spq_pkg::*;

  `SPQ_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `SPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_status), "stalled result changed")
  `SPQ_ASSERT(a_empty_prio, out_valid && (out_entry_count == '0) |-> (out_head_priority == '0), "empty queue with nonzero priority")
  `SPQ_ASSERT(a_full_drop, out_valid && (out_status == ST_FULL) |-> (out_entry_count == CNT_W'(DEPTH)), "full drop while not full")
  `SPQ_ASSERT(a_empty_status, out_valid && (out_status == ST_EMPTY) |-> (out_entry_count == '0), "empty status with entries held")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_tag           (out_tag),
  .out_head_priority (out_head_priority),
  .out_entry_count   (out_entry_count),
  .out_status        (out_status)
);

// ----- bench/priority_queue_checker.sv -----
// ----------------------------------------------------------------------------
// Priority queue result checker
// Watches both channels of the sorted priority queue, keeps its own sorted
// copy of the slots, and compares every result beat with the oldest report
// that the accepted requests have predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_queue_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [spq_pkg::TAG_W-1:0]         in_tag,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [spq_pkg::TAG_W-1:0]         out_tag,
  input  logic signed [spq_pkg::PRIO_W-1:0] out_head_priority,
  input  logic [spq_pkg::CNT_W-1:0]         out_entry_count,
  input  logic [2:0]                        out_status,
  output int                                error_count,
  output int                                pending_count
);
  import spq_pkg::*;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
    logic [2:0]        status;
  } queue_report_t;

  // Sorted copy of the queue; slot 0 is the head.
  logic [TAG_W-1:0]         slot_tags  [DEPTH];
  logic signed [PRIO_W-1:0] slot_prios [DEPTH];
  int                       held;

  queue_report_t expected_reports [$];
  queue_report_t want;

  // New entry goes ahead of the first entry with a larger priority, or an
  // equal priority and a tag that is not smaller.
  function automatic void place_entry(input logic [TAG_W-1:0] t,
                                      input logic signed [PRIO_W-1:0] p);
    int pos;
    int i;
    pos = 0;
    while (pos < held &&
           (slot_prios[pos] < p || (slot_prios[pos] == p && slot_tags[pos] < t)))
      pos++;
    for (i = held; i > pos; i--) begin
      slot_tags[i]  = slot_tags[i-1];
      slot_prios[i] = slot_prios[i-1];
    end
    slot_tags[pos]  = t;
    slot_prios[pos] = p;
    held++;
  endfunction

  function automatic void take_out(input int pos);
    int i;
    for (i = pos; i + 1 < held; i++) begin
      slot_tags[i]  = slot_tags[i+1];
      slot_prios[i] = slot_prios[i+1];
    end
    held--;
  endfunction

  function automatic queue_report_t apply_request(input logic [1:0] req,
                                                  input logic [TAG_W-1:0] t,
                                                  input logic signed [PRIO_W-1:0] p);
    queue_report_t rpt;
    logic          removed;
    int            hit;
    int            i;
    rpt        = '0;
    rpt.status = ST_OK;
    removed    = 1'b0;
    hit        = -1;
    case (req)
      REQ_INSERT: begin
        if (held >= DEPTH) rpt.status = ST_FULL;
        else place_entry(t, p);
      end
      REQ_REMOVE: begin
        if (held == 0) begin
          rpt.status = ST_EMPTY;
        end else begin
          rpt.tag = slot_tags[0];
          removed = 1'b1;
          take_out(0);
        end
      end
      REQ_LOWER: begin
        // Only the first holder of the tag, counted from the head, is changed.
        for (i = 0; i < held; i++)
          if (hit < 0 && slot_tags[i] == t) hit = i;
        if (hit < 0) begin
          rpt.status = ST_NOTFOUND;
        end else if (slot_prios[hit] < p) begin
          rpt.status = ST_URGENT;
        end else begin
          take_out(hit);
          place_entry(t, p);
        end
      end
      REQ_REPORT: begin
        if (held == 0) rpt.status = ST_EMPTY;
      end
    endcase
    if (!removed && held > 0) rpt.tag = slot_tags[0];
    if (held > 0) rpt.prio = slot_prios[0];
    rpt.count = CNT_W'(held);
    return rpt;
  endfunction

  task automatic note_mismatch(input string field, input longint expv, input longint actv);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held        = 0;
      error_count = 0;
      expected_reports.delete();
    end else begin
      // The result side goes first so that a beat can never be matched
      // against a request accepted on the same edge.
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: result beat with none expected, got tag %0d prio %0d count %0d status %0d",
                   $time, out_tag, out_head_priority, out_entry_count, out_status);
        end else begin
          want = expected_reports.pop_front();
          if (out_tag !== want.tag)
            note_mismatch("out_tag", want.tag, out_tag);
          if (out_head_priority !== want.prio)
            note_mismatch("out_head_priority", $signed(want.prio), out_head_priority);
          if (out_entry_count !== want.count)
            note_mismatch("out_entry_count", want.count, out_entry_count);
          if (out_status !== want.status)
            note_mismatch("out_status", want.status, out_status);
        end
      end
      if (in_valid && in_ready)
        expected_reports.push_back(apply_request(in_req_type, in_tag, in_priority_req));
    end
    pending_count = expected_reports.size();
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives requests into the queue with random gaps and back-pressure on the
// result side, first a directed pass over the corner cases and then random
// phases that fill, drain or churn the queue. A checker beside the block
// predicts and compares every result; this module only gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT  = 200;

  typedef enum {FILL_HEAVY, DRAIN_HEAVY, BALANCED} load_mix_t;

  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_req_type = REQ_REPORT;
  logic [TAG_W-1:0]         in_tag = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [TAG_W-1:0]         out_tag;
  logic signed [PRIO_W-1:0] out_head_priority;
  logic [CNT_W-1:0]         out_entry_count;
  logic [2:0]               out_status;
  int                       error_count;
  int                       pending_count;

  // When set, the matching side of the bench runs without idle cycles.
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  int sink_wait  = 0;
  // Registered flag, set on the clock edge at which a result beat was taken.
  bit out_beat   = 1'b0;

  // A small pool of tags makes repeats common, so priority changes find
  // their entries and equal tags meet in the sorted order.
  logic [TAG_W-1:0] tag_pool [8];

  sorted_priority_queue dut (.*);

  priority_queue_checker report_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: after each accepted beat, hold ready low for a random
  // number of cycles. Ready is changed only at the falling edge.
  always @(posedge clk) begin
    out_beat <= out_valid && out_ready;
  end

  always @(negedge clk) begin : sink_pace
    int wait_now;
    wait_now = sink_wait;
    if (out_beat) wait_now = sink_quiet ? 0 : $urandom_range(0, 7);
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (wait_now > 0) begin
      out_ready <= 1'b0;
      sink_wait <= wait_now - 1;
    end else begin
      out_ready <= 1'b1;
      sink_wait <= 0;
    end
  end

  // Watchdog: any beat on either channel, or reset, restarts the count.
  initial begin
    int idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Sends one request beat. It is entered and left just after a falling
  // edge. With no gap, valid simply stays high and the next payload takes
  // the place of the last one, so valid is never dropped and raised in the
  // same step.
  task automatic issue_request(input logic [1:0] req, input logic [TAG_W-1:0] tag,
                               input logic [PRIO_W-1:0] prio);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_tag          <= tag;
    in_priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until the checker has seen every result that
  // the accepted requests owe. At least one falling edge always passes, so
  // a following beat raises valid in a later step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 9) < 7) return tag_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Priorities lean toward the extremes and a narrow band around zero, where
  // ties are frequent; the rest cover the whole range.
  function automatic logic [PRIO_W-1:0] pick_prio();
    logic [PRIO_W-1:0] p;
    int                roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)     p = {1'b1, {(PRIO_W-1){1'b0}}};
    else if (roll == 1) p = {1'b0, {(PRIO_W-1){1'b1}}};
    else if (roll < 6) p = PRIO_W'(int'($urandom_range(0, 6)) - 3);
    else               p = PRIO_W'($urandom);
    return p;
  endfunction

  function automatic logic [1:0] pick_request(input load_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      FILL_HEAVY: begin
        if (roll < 65)      return REQ_INSERT;
        else if (roll < 80) return REQ_LOWER;
        else if (roll < 92) return REQ_REMOVE;
      end
      DRAIN_HEAVY: begin
        if (roll < 15)      return REQ_INSERT;
        else if (roll < 30) return REQ_LOWER;
        else if (roll < 85) return REQ_REMOVE;
      end
      default: begin
        if (roll < 35)      return REQ_INSERT;
        else if (roll < 65) return REQ_LOWER;
        else if (roll < 90) return REQ_REMOVE;
      end
    endcase
    return REQ_REPORT;
  endfunction

  initial begin
    load_mix_t mix;
    int        sent;
    int        phase_no;
    int        phase_len;
    int        i;

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (i = 2; i < 8; i++) tag_pool[i] = $urandom;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass. On the empty queue a report, a remove and a priority change
    // each report empty or not found.
    issue_request(REQ_REPORT, '0, '0);
    issue_request(REQ_REMOVE, '0, '0);
    issue_request(REQ_LOWER, '0, '0);
    // Extreme tags with extreme priorities, then two ties on priority where
    // the smaller tag must come first, and an exact duplicate.
    issue_request(REQ_INSERT, '1, 16'sh7fff);
    issue_request(REQ_INSERT, '0, 16'sh8000);
    issue_request(REQ_INSERT, 32'd5, '0);
    issue_request(REQ_INSERT, 32'd3, '0);
    issue_request(REQ_INSERT, 32'd3, '0);
    // Priority changes: down to the minimum, where it ties with the head and
    // goes behind the smaller tag; to an equal priority, which is accepted;
    // upward, which is refused because the entry is already more urgent;
    // one on a duplicated tag, which moves only the first holder; and one
    // on a tag that is not held.
    issue_request(REQ_LOWER, 32'd5, 16'sh8000);
    issue_request(REQ_LOWER, '1, 16'sh7fff);
    issue_request(REQ_LOWER, 32'd3, 16'sd100);
    issue_request(REQ_LOWER, 32'd3, -16'sd1);
    issue_request(REQ_LOWER, 32'h1234_5678, '0);
    issue_request(REQ_REPORT, '0, '0);
    // Drain the five entries and remove once more from the empty queue.
    repeat (6) issue_request(REQ_REMOVE, '0, '0);

    // Random phases. The first one is insert heavy and long enough to
    // overflow the queue; later ones are chosen at random. Some phases run
    // without idle cycles on one side or the other.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_no == 0) begin
        mix       = FILL_HEAVY;
        phase_len = 60;
      end else begin
        mix       = load_mix_t'($urandom_range(0, 2));
        phase_len = $urandom_range(20, 60);
      end
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        issue_request(pick_request(mix), pick_tag(), pick_prio());
        sent++;
      end
      // Now and then, and always after the first phase, the sender holds
      // off until every outstanding result has come back.
      if (phase_no == 0 || $urandom_range(0, 2) == 0) wait_for_results();
      phase_no++;
    end

    wait_for_results();
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
